// ----- rtl/core/dec_pkg.sv -----
// ----------------------------------------------------------------------------
// dec_pkg
// Shared types and constants of the four-channel debounced edge counter.
// ----------------------------------------------------------------------------
package dec_pkg;

  // Channels that are built; result fields exist for NCH of them.
  localparam int CHANNELS  = 4;
  localparam int NCH       = 4;

  localparam int DEB_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_CH0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_CH1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_CH2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_CH3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_STATUS_EN   = 3'd4;

  localparam logic [NCH-1:0] LED_EN_RESET = 4'hF;

  typedef struct packed {
    logic [NCH-1:0]    pin_levels;
    logic [TIME_W-1:0] now_ms;
  } dec_in_t;

  typedef struct packed {
    logic [NCH-1:0]   value_mask;
    logic [NCH-1:0]   led_drive;
    logic [CNT_W-1:0] rising_count_0;
    logic [CNT_W-1:0] rising_count_1;
    logic [CNT_W-1:0] rising_count_2;
    logic [CNT_W-1:0] rising_count_3;
    logic [CNT_W-1:0] falling_count_0;
    logic [CNT_W-1:0] falling_count_1;
    logic [CNT_W-1:0] falling_count_2;
    logic [CNT_W-1:0] falling_count_3;
  } dec_out_t;

  // Per-channel control handed from the top level to a channel slice.
  typedef struct packed {
    logic              update;
    logic              level;
    logic [TIME_W-1:0] now_ms;
    logic [DEB_W-1:0]  debounce;
    logic              led_en;
  } dec_chan_ctl_t;

endpackage

// ----- rtl/core/dec_cfg.sv -----
// ----------------------------------------------------------------------------
// dec_cfg
// Configuration register file: four debounce windows and the LED mode bits.
// ----------------------------------------------------------------------------
module dec_cfg
  import dec_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  output logic [NCH-1:0][DEB_W-1:0]  debounce,
  output logic [NCH-1:0]             led_en
);

  logic [NCH-1:0][DEB_W-1:0] debounce_r, debounce_nxt;
  logic [NCH-1:0]            led_en_r, led_en_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    debounce_nxt = debounce_r;
    led_en_nxt   = led_en_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE_CH0:  debounce_nxt[0] = cfg_data[DEB_W-1:0];
        REG_DEBOUNCE_CH1:  debounce_nxt[1] = cfg_data[DEB_W-1:0];
        REG_DEBOUNCE_CH2:  debounce_nxt[2] = cfg_data[DEB_W-1:0];
        REG_DEBOUNCE_CH3:  debounce_nxt[3] = cfg_data[DEB_W-1:0];
        REG_LED_STATUS_EN: led_en_nxt      = cfg_data[NCH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= '0;
      led_en_r   <= LED_EN_RESET;
    end else begin
      debounce_r <= debounce_nxt;
      led_en_r   <= led_en_nxt;
    end
  end

  assign debounce = debounce_r;
  assign led_en   = led_en_r;

endmodule

// ----- rtl/core/dec_chan.sv -----
// ----------------------------------------------------------------------------
// dec_chan
// One channel: debounce window check, edge counters and status LED state.
// ----------------------------------------------------------------------------
module dec_chan
  import dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dec_chan_ctl_t     ctl,
  output logic [CNT_W-1:0]  rise_cnt,
  output logic [CNT_W-1:0]  fall_cnt,
  output logic              led
);

  logic              last_level_r, last_level_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]  rise_r, rise_nxt;
  logic [CNT_W-1:0]  fall_r, fall_nxt;
  logic              led_r, led_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  // The elapsed time wraps, so the subtraction is taken modulo 2^32.
  assign elapsed = ctl.now_ms - start_r;
  assign expired = elapsed >= {{(TIME_W-DEB_W){1'b0}}, ctl.debounce};

  always_comb begin
    last_level_nxt = last_level_r;
    start_nxt      = start_r;
    rise_nxt       = rise_r;
    fall_nxt       = fall_r;
    led_nxt        = led_r;
    if (ctl.update) begin
      if (expired) begin
        if (!last_level_r && ctl.level) begin
          rise_nxt = rise_r + 1'b1;
        end else if (last_level_r && !ctl.level) begin
          fall_nxt = fall_r + 1'b1;
        end
        last_level_nxt = ctl.level;
        start_nxt      = ctl.now_ms;
      end
      // The LED follows the live level, not the debounced one.
      if (ctl.led_en) begin
        led_nxt = ~ctl.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      start_r      <= '0;
      rise_r       <= '0;
      fall_r       <= '0;
      led_r        <= 1'b1;
    end else begin
      last_level_r <= last_level_nxt;
      start_r      <= start_nxt;
      rise_r       <= rise_nxt;
      fall_r       <= fall_nxt;
      led_r        <= led_nxt;
    end
  end

  assign rise_cnt = rise_r;
  assign fall_cnt = fall_r;
  assign led      = led_r;

endmodule

// ----- rtl/core/debounced_edge_counter_4ch_top.sv -----
// ----------------------------------------------------------------------------
// debounced_edge_counter_4ch_top
// Four-channel debounced rising and falling edge counter with status LEDs.
// ----------------------------------------------------------------------------
// Stages: input register, then output stage. One item per cycle while the
// output does not stall; each channel's window check and counter
// update is a single 32-bit subtract, compare and increment.
// Reset: synchronous; counters, levels and window starts clear, LEDs go off,
// debounce windows read 0 and all LEDs are in status mode.
// ----------------------------------------------------------------------------
module debounced_edge_counter_4ch_top
  import dec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dec_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dec_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                      s1_valid_r, s1_valid_nxt;
  dec_in_t                   s1_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [NCH-1:0]            mask_r, mask_nxt;
  logic                      advance;
  logic                      in_accept;
  logic [NCH-1:0]            level;
  logic [NCH-1:0][DEB_W-1:0] debounce;
  logic [NCH-1:0]            led_en;
  logic [NCH-1:0][CNT_W-1:0] rise_cnt;
  logic [NCH-1:0][CNT_W-1:0] fall_cnt;
  logic [NCH-1:0]            led;

  dec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .debounce  (debounce),
    .led_en    (led_en)
  );

  // The channel state doubles as the result register: it only moves when
  // an item passes into the output stage, and holds while that stage stalls.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign level     = ~s1_data_r.pin_levels;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    mask_r <= mask_nxt;
  end

  for (genvar g = 0; g < NCH; g++) begin : g_chan
    if (g < CHANNELS) begin : g_on
      dec_chan_ctl_t ctl;

      assign ctl.update   = advance;
      assign ctl.level    = level[g];
      assign ctl.now_ms   = s1_data_r.now_ms;
      assign ctl.debounce = debounce[g];
      assign ctl.led_en   = led_en[g];
      assign mask_nxt[g]  = advance ? level[g] : mask_r[g];

      dec_chan u_chan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rise_cnt (rise_cnt[g]),
        .fall_cnt (fall_cnt[g]),
        .led      (led[g])
      );
    end else begin : g_off
      assign mask_nxt[g] = 1'b0;
      assign rise_cnt[g] = '0;
      assign fall_cnt[g] = '0;
      assign led[g]      = 1'b1;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.value_mask      = mask_r;
  assign out_data.led_drive       = led;
  assign out_data.rising_count_0  = rise_cnt[0];
  assign out_data.rising_count_1  = rise_cnt[1];
  assign out_data.rising_count_2  = rise_cnt[2];
  assign out_data.rising_count_3  = rise_cnt[3];
  assign out_data.falling_count_0 = fall_cnt[0];
  assign out_data.falling_count_1 = fall_cnt[1];
  assign out_data.falling_count_2 = fall_cnt[2];
  assign out_data.falling_count_3 = fall_cnt[3];

endmodule

// ----- rtl/core/dec_checker.sv -----
// ----------------------------------------------------------------------------
// dec_checker
// Port-level checks on the debounced edge counter, bound to its top level.
// ----------------------------------------------------------------------------
module dec_checker
  import dec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  dec_out_t             out_data
);

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An item taken with no result showing becomes valid after the input stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("accepted item did not reach the output");

  // Between consecutive results, channel 0's counters move by at most one.
  a_rise_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid ||
      CNT_W'(out_data.rising_count_0 - $past(out_data.rising_count_0)) <= 1)
    else $error("rising count jumped");

  a_fall_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid ||
      CNT_W'(out_data.falling_count_0 - $past(out_data.falling_count_0)) <= 1)
    else $error("falling count jumped");

endmodule

bind debounced_edge_counter_4ch_top dec_checker u_dec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/debounced_edge_counter_4ch_top_tb.sv -----
// ----------------------------------------------------------------------------
// debounced_edge_counter_4ch_top_tb
// Self-checking bench for the four-channel debounced edge counter. It drives
// directed and random pin samples with a wrapping millisecond clock, changes
// the debounce windows and LED modes between phases, and compares every
// result with a cycle-free prediction of the counts, level mask and LEDs.
// ----------------------------------------------------------------------------
module debounced_edge_counter_4ch_top_tb;
  import dec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 100;

  // Prediction of the counter state and the queue of results still owed.
  class edge_tally_board;
    logic [DEB_W-1:0]  debounce [NCH];
    logic [NCH-1:0]    led_en;
    logic              last_lvl [NCH];
    logic [TIME_W-1:0] win_start [NCH];
    logic [CNT_W-1:0]  rise_cnt [NCH];
    logic [CNT_W-1:0]  fall_cnt [NCH];
    logic              led_st [NCH];
    dec_out_t          tallies [$];
    int                errors;

    function new();
      for (int i = 0; i < NCH; i++) begin
        debounce[i]  = '0;
        last_lvl[i]  = 1'b0;
        win_start[i] = '0;
        rise_cnt[i]  = '0;
        fall_cnt[i]  = '0;
        led_st[i]    = 1'b1;
      end
      led_en = LED_EN_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_DEBOUNCE_CH0:  debounce[0] = data;
        REG_DEBOUNCE_CH1:  debounce[1] = data;
        REG_DEBOUNCE_CH2:  debounce[2] = data;
        REG_DEBOUNCE_CH3:  debounce[3] = data;
        REG_LED_STATUS_EN: led_en = data[NCH-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(dec_in_t s);
      dec_out_t          r;
      logic              lvl;
      logic [TIME_W-1:0] elapsed;
      r = '0;
      for (int i = 0; i < NCH; i++) begin
        lvl = ~s.pin_levels[i];
        elapsed = s.now_ms - win_start[i];
        if (elapsed >= TIME_W'(debounce[i])) begin
          if (!last_lvl[i] && lvl) rise_cnt[i] = rise_cnt[i] + 1'b1;
          else if (last_lvl[i] && !lvl) fall_cnt[i] = fall_cnt[i] + 1'b1;
          last_lvl[i]  = lvl;
          win_start[i] = s.now_ms;
        end
        if (led_en[i]) led_st[i] = ~lvl;
        r.value_mask[i] = lvl;
        r.led_drive[i]  = led_st[i];
      end
      r.rising_count_0  = rise_cnt[0];
      r.rising_count_1  = rise_cnt[1];
      r.rising_count_2  = rise_cnt[2];
      r.rising_count_3  = rise_cnt[3];
      r.falling_count_0 = fall_cnt[0];
      r.falling_count_1 = fall_cnt[1];
      r.falling_count_2 = fall_cnt[2];
      r.falling_count_3 = fall_cnt[3];
      tallies.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_tally(dec_out_t got);
      dec_out_t want;
      if (tallies.size() == 0) begin
        $display("%0t ns: result with nothing expected, got %h", $time, got);
        errors++;
        return;
      end
      want = tallies.pop_front();
      compare("value_mask", 32'(want.value_mask), 32'(got.value_mask));
      compare("led_drive", 32'(want.led_drive), 32'(got.led_drive));
      compare("rising_count_0", want.rising_count_0, got.rising_count_0);
      compare("rising_count_1", want.rising_count_1, got.rising_count_1);
      compare("rising_count_2", want.rising_count_2, got.rising_count_2);
      compare("rising_count_3", want.rising_count_3, got.rising_count_3);
      compare("falling_count_0", want.falling_count_0, got.falling_count_0);
      compare("falling_count_1", want.falling_count_1, got.falling_count_1);
      compare("falling_count_2", want.falling_count_2, got.falling_count_2);
      compare("falling_count_3", want.falling_count_3, got.falling_count_3);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  dec_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  dec_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  edge_tally_board board;

  // Sender pacing and receiver behaviour, set per phase by the main sequence.
  int  gap_max;
  int  burst_left;
  int  stall_mode;
  bit  hold_req;
  int  hold_left;
  int  stall_cyc;
  int  quiet;

  logic [NCH-1:0]    cur_pins;
  logic [TIME_W-1:0] cur_ms;

  always #6 clk = ~clk;

  debounced_edge_counter_4ch_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_sample(in_data);
      if (out_valid && !out_stall) board.check_tally(out_data);
    end
  end

  // Receiver: a stall pattern per phase, plus a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    stall_cyc = 0;
    forever begin
      @(posedge clk);
      stall_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((stall_cyc % 7) < 3);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("debounced_edge_counter_4ch_top_tb: errors");
        $finish;
      end
    end
  end

  // Offers one item and returns once it has been taken. Bursts of items are
  // separated by random gaps.
  task automatic send_sample(input dec_in_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data  <= dec_in_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Rewrites every register once the block has drained; the unused indexes
  // are hit as well.
  task automatic program_regs(input logic [DEB_W-1:0] w0, input logic [DEB_W-1:0] w1,
                              input logic [DEB_W-1:0] w2, input logic [DEB_W-1:0] w3,
                              input logic [CFG_DAT_W-1:0] led_word);
    logic [DEB_W-1:0] win [NCH];
    while (board.tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    win = '{w0, w1, w2, w3};
    for (int i = 0; i < NCH + 4; i++) begin
      cfg_valid <= 1'b1;
      if (i < NCH) begin
        cfg_index <= REG_DEBOUNCE_CH0 + CFG_IDX_W'(i);
        cfg_data  <= win[i];
      end else if (i == NCH) begin
        cfg_index <= REG_LED_STATUS_EN;
        cfg_data  <= led_word;
      end else begin
        cfg_index <= REG_LED_STATUS_EN + CFG_IDX_W'(i - NCH);
        cfg_data  <= CFG_DAT_W'($urandom);
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Pins mostly bounce a bit at a time; time mostly creeps forward, with
  // jumps across the long windows, arbitrary jumps and runs up to the wrap.
  function automatic dec_in_t next_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) cur_ms = cur_ms + $urandom_range(0, 6);
    else if (r < 85) cur_ms = cur_ms + $urandom_range(0, 60);
    else if (r < 92) cur_ms = cur_ms + $urandom_range(60000, 70000);
    else if (r < 97) cur_ms = $urandom;
    else cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 8);
    if ($urandom_range(0, 9) == 0) cur_pins = NCH'($urandom);
    else cur_pins = cur_pins ^ NCH'($urandom & $urandom);
    return dec_in_t'({cur_pins, cur_ms});
  endfunction

  initial begin
    logic [DEB_W-1:0] w [NCH];
    int               r;
    board      = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gap_max    = 3;
    burst_left = 0;
    stall_mode = 1;
    hold_req   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero windows after reset: every sample is checked, all LEDs follow.
    send_sample(dec_in_t'({4'hF, 32'h0000_0000}));
    send_sample(dec_in_t'({4'h0, 32'h0000_0001}));
    send_sample(dec_in_t'({4'hF, 32'h0000_0002}));
    send_sample(dec_in_t'({4'hA, 32'h0000_0003}));
    send_sample(dec_in_t'({4'h5, 32'hFFFF_FFFF}));
    send_sample(dec_in_t'({4'h0, 32'h0000_0000}));
    in_valid <= 1'b0;

    // Windows at exact expiry, one short of it, the maximum and across the
    // wrap of the millisecond clock; two LEDs in status mode.
    program_regs(16'd2, 16'hFFFF, 16'd5, 16'd0, 16'hFFF6);
    send_sample(dec_in_t'({4'hF, 32'h0000_0001}));
    send_sample(dec_in_t'({4'hF, 32'h0000_0002}));
    send_sample(dec_in_t'({4'h0, 32'h0000_0006}));
    send_sample(dec_in_t'({4'hF, 32'h0001_0000}));
    send_sample(dec_in_t'({4'h0, 32'h0001_FFFF}));
    send_sample(dec_in_t'({4'hF, 32'h0002_FFFD}));
    send_sample(dec_in_t'({4'h5, 32'hFFFF_FFFE}));
    send_sample(dec_in_t'({4'hA, 32'h0000_0003}));
    in_valid <= 1'b0;

    // All LEDs held.
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
    send_sample(dec_in_t'({4'h0, 32'h0000_0004}));
    send_sample(dec_in_t'({4'hF, 32'h0000_0005}));
    in_valid <= 1'b0;
    cur_pins = 4'hF;
    cur_ms   = 32'h0000_0005;

    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < NCH; i++) begin
        r = $urandom_range(0, 99);
        if (p == 0 || r < 15) w[i] = '0;
        else if (p == 1 || r < 25) w[i] = 16'hFFFF;
        else w[i] = DEB_W'($urandom_range(1, 30));
      end
      if (p == 0) program_regs(w[0], w[1], w[2], w[3], 16'h000F);
      else if (p == 1) program_regs(w[0], w[1], w[2], w[3], 16'h0000);
      else program_regs(w[0], w[1], w[2], w[3], CFG_DAT_W'($urandom));
      gap_max    = (p % 3 == 2) ? 0 : 5;
      stall_mode = p % 4;
      // With the sender never pausing, a long hold-off fills the pipeline.
      if (p % 3 == 2) hold_req = 1'b1;
      for (int n = 0; n < 148; n++) send_sample(next_sample());
      in_valid <= 1'b0;
    end

    while (board.tallies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.tallies.size() == 0) begin
      $display("debounced_edge_counter_4ch_top_tb: clean");
    end else begin
      $display("debounced_edge_counter_4ch_top_tb: errors");
    end
    $finish;
  end

endmodule
